// File: hw/rtl/bpp_pkg.sv
// buzzer pattern player: shared types and constants
// request and result payloads, queue entry layout, opcodes
// no dependencies
`timescale 1ns / 1ps

package bpp_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_ENQUEUE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam int unsigned PATTERN_W = 32;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned PERIOD_W  = 6;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 6'd32;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [PATTERN_W-1:0] pattern;
		logic [COUNT_W-1:0]   repeat_count;
		logic [COUNT_W-1:0]   slice_count;
		logic                 beep_enable;
	} item_t;

	typedef struct packed {
		logic buzzer_level;
		logic busy_res;
		logic dropped_oldest;
	} result_t;

	// one queued alarm, already sanitized: repeats 1..255, period 1..32
	typedef struct packed {
		logic [PATTERN_W-1:0] pattern;
		logic [COUNT_W-1:0]   repeats;
		logic [PERIOD_W-1:0]  period;
		logic                 beep;
	} entry_t;

endpackage

// File: hw/rtl/buzzer_pattern_player_unit.sv
// buzzer pattern player top level
// request register, single-pass control logic, result register, alarm ring
// depends on bpp_pkg and bpp_queue
`timescale 1ns / 1ps

// Usage
//   item channel (item_valid / item_stall / item): one request per transfer,
//   opcode tick, enqueue alarm or clear. Every request yields exactly one
//   result on the result channel (result_valid / result_stall / result):
//   pin level, busy flag and the dropped-oldest flag of that request.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): pin polarity, written
//   while no request is in flight; cfg_ready is always high.
//   Data path: an accepted request is registered in the request register,
//   evaluated combinationally, and its result is registered in the result
//   register, from which the receiver takes it.
//   Throughput: one request per cycle without result stalls, set by the
//   single evaluation stage between the request and result registers.
//   When the receiver stalls, the result register holds; the request
//   register still takes one more request, then item_stall rises.
//   Reset (arst_n low) empties the queue, stops playback, silences the pin
//   and sets polarity to active high. Queue entries are not cleared.

module buzzer_pattern_player_unit #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bpp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bpp_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		ring_next = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
	endfunction

	// request stage
	logic           valid_s1;
	bpp_pkg::item_t item_s1;
	logic           advance;

	// result register
	logic             res_valid_q;
	bpp_pkg::result_t res_q;
	bpp_pkg::result_t res_nxt;

	// player state
	logic [IDX_W-1:0]             wr_idx_q, wr_idx_n;
	logic [IDX_W-1:0]             rd_idx_q, rd_idx_n;
	logic                         playing_q, playing_n;
	logic [bpp_pkg::PATTERN_W-1:0] saved_q, saved_n;
	logic [bpp_pkg::PATTERN_W-1:0] shift_q, shift_n;
	logic [bpp_pkg::PERIOD_W-1:0] slices_q, slices_n;
	logic [bpp_pkg::COUNT_W-1:0]  repeats_q, repeats_n;
	logic [bpp_pkg::PERIOD_W-1:0] period_q, period_n;
	logic                         beep_q, beep_n;
	logic                         sound_q, sound_n;
	logic                         active_high_q;

	// queue interface
	logic             q_we;
	logic [IDX_W-1:0] q_rd_addr;
	bpp_pkg::entry_t  q_rd_entry;
	bpp_pkg::entry_t  new_entry;

	assign advance    = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall = valid_s1 && res_valid_q && result_stall;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			active_high_q <= cfg_data;
		end
	end

	// sanitized form of an enqueued alarm
	always_comb begin
		new_entry.pattern = item_s1.pattern;
		new_entry.repeats = (item_s1.repeat_count == '0) ?
			bpp_pkg::COUNT_W'(1) : item_s1.repeat_count;
		if ((item_s1.slice_count == '0) ||
				(item_s1.slice_count > bpp_pkg::COUNT_W'(bpp_pkg::PERIOD_MAX))) begin
			new_entry.period = bpp_pkg::PERIOD_MAX;
		end else begin
			new_entry.period = item_s1.slice_count[bpp_pkg::PERIOD_W-1:0];
		end
		new_entry.beep = item_s1.beep_enable;
	end

	always_comb begin
		logic                         load_en;
		bpp_pkg::entry_t              load_entry;
		logic [bpp_pkg::PERIOD_W-1:0] slices_inc;
		logic [bpp_pkg::COUNT_W-1:0]  repeats_dec;
		logic                         dropped;

		wr_idx_n    = wr_idx_q;
		rd_idx_n    = rd_idx_q;
		playing_n   = playing_q;
		saved_n     = saved_q;
		shift_n     = shift_q;
		slices_n    = slices_q;
		repeats_n   = repeats_q;
		period_n    = period_q;
		beep_n      = beep_q;
		sound_n     = sound_q;
		q_we        = 1'b0;
		load_en     = 1'b0;
		load_entry  = q_rd_entry;
		dropped     = 1'b0;
		slices_inc  = slices_q + bpp_pkg::PERIOD_W'(1);
		repeats_dec = (repeats_q != '0) ? repeats_q - bpp_pkg::COUNT_W'(1) : repeats_q;

		case (item_s1.opcode)
			bpp_pkg::OP_ENQUEUE: begin
				if (ring_next(wr_idx_q) == rd_idx_q) begin
					rd_idx_n = ring_next(rd_idx_q);
					dropped  = 1'b1;
				end
				q_we     = 1'b1;
				wr_idx_n = ring_next(wr_idx_q);
				// idle means an empty ring, so the head is the alarm just written
				if (!playing_q) begin
					load_en    = 1'b1;
					load_entry = new_entry;
				end
			end
			bpp_pkg::OP_TICK: begin
				if (!playing_q) begin
					if (wr_idx_q == rd_idx_q) begin
						sound_n = 1'b0;
					end else begin
						load_en = 1'b1;
					end
				end else begin
					sound_n = shift_q[0] && beep_q;
					shift_n = shift_q >> 1;
					if (slices_inc >= period_q) begin
						slices_n  = '0;
						repeats_n = repeats_dec;
						if (repeats_dec != '0) begin
							shift_n = saved_q;
						end else begin
							playing_n = 1'b0;
							sound_n   = 1'b0;
							if (wr_idx_q != rd_idx_q) begin
								load_en = 1'b1;
							end
						end
					end else begin
						slices_n = slices_inc;
					end
				end
			end
			bpp_pkg::OP_CLEAR: begin
				wr_idx_n  = '0;
				rd_idx_n  = '0;
				playing_n = 1'b0;
				sound_n   = 1'b0;
			end
			default: begin
			end
		endcase

		if (load_en) begin
			saved_n   = load_entry.pattern;
			shift_n   = load_entry.pattern;
			repeats_n = load_entry.repeats;
			period_n  = load_entry.period;
			beep_n    = load_entry.beep;
			slices_n  = '0;
			playing_n = 1'b1;
			rd_idx_n  = ring_next(rd_idx_n);
		end

		res_nxt.buzzer_level   = sound_n ^ ~active_high_q;
		res_nxt.busy_res       = playing_n || (wr_idx_n != rd_idx_n);
		res_nxt.dropped_oldest = dropped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			playing_q <= 1'b0;
			saved_q   <= '0;
			shift_q   <= '0;
			slices_q  <= '0;
			repeats_q <= '0;
			period_q  <= bpp_pkg::PERIOD_MAX;
			beep_q    <= 1'b1;
			sound_q   <= 1'b0;
		end else if (advance) begin
			wr_idx_q  <= wr_idx_n;
			rd_idx_q  <= rd_idx_n;
			playing_q <= playing_n;
			saved_q   <= saved_n;
			shift_q   <= shift_n;
			slices_q  <= slices_n;
			repeats_q <= repeats_n;
			period_q  <= period_n;
			beep_q    <= beep_n;
			sound_q   <= sound_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// head read always follows the read index that is about to be current
	assign q_rd_addr = advance ? rd_idx_n : rd_idx_q;

	bpp_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.wr_en    (q_we && advance),
		.wr_addr  (wr_idx_q),
		.wr_entry (new_entry),
		.rd_addr  (q_rd_addr),
		.rd_entry (q_rd_entry)
	);

endmodule

// File: hw/rtl/bpp_queue.sv
// buzzer pattern player: alarm ring storage
// one write port, one registered read port with write-through on the same address
// depends on bpp_pkg
`timescale 1ns / 1ps

module bpp_queue #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
	input  bpp_pkg::entry_t                wr_entry,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
	output bpp_pkg::entry_t                rd_entry
);

	bpp_pkg::entry_t mem [QUEUE_DEPTH];
	bpp_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	// read data tracks the head; a write to the head address shows up at once
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_entry;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_entry = rd_q;

endmodule

// File: hw/rtl/bpp_checker.sv
// buzzer pattern player: port-level checker and its bind to the top level
// sees only the top level ports
// depends on bpp_pkg
`timescale 1ns / 1ps

module bpp_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input bpp_pkg::result_t result
);

	// held result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// requests back up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("request stalled with free result register");

	// an accepted request reaches the result register once it is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall ##1 (!result_valid || !result_stall) |=> result_valid)
		else $error("request result missing");

	// a dropped entry means the ring was full, so the block is busy
	a_drop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dropped_oldest |-> result.busy_res)
		else $error("drop reported while not busy");

endmodule

bind buzzer_pattern_player_unit bpp_checker u_bpp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
